### src/v4alu_pkg.sv
// ----------------------------------------------------------------------------
// v4alu_pkg
// Shared types and constants for the four-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v4alu_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_W        = 32;
   localparam int LANES         = 4;
   localparam int TOL_W         = 31;
   localparam logic [TOL_W-1:0] TOL_RESET = 31'd7;
   localparam int SUMSQ_W       = 64;
   localparam int ROOT_W        = 33;
   localparam int REQ_DATA_W    = 296;
   localparam int RSP_DATA_W    = 168;

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_NEG   = 4'd2,
      OP_SCALE = 4'd3,
      OP_DIV   = 4'd4,
      OP_EQUAL = 4'd5,
      OP_MAG   = 4'd6,
      OP_NORM  = 4'd7,
      OP_DOT   = 4'd8,
      OP_CROSS = 4'd9
   } opcode_type;

   // What an item carries past the product stages.
   typedef struct packed {
      opcode_type                   op;
      logic [LANES-1:0][WORD_W-1:0] r;
      logic [WORD_W-1:0]            sc;
      logic                         eq;
      logic [LANES-1:0][WORD_W-1:0] a;
      logic [WORD_W-1:0]            f;
   } info_type;

   typedef struct packed {
      info_type             info;
      logic [SUMSQ_W-1:0]   sumsq;
   } front_type;

endpackage

### src/v4alu_front.sv
// ----------------------------------------------------------------------------
// v4alu_front
// Two register stages: operand selection into six shared multipliers plus the
// simple lane operations, then product sums, rounding and saturation.
// ----------------------------------------------------------------------------
module v4alu_front #(
   parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    en,
   input  logic                                                    in_valid,
   input  v4alu_pkg::opcode_type                                   in_op,
   input  logic [v4alu_pkg::LANES-1:0][v4alu_pkg::WORD_W-1:0]      in_a,
   input  logic [v4alu_pkg::LANES-1:0][v4alu_pkg::WORD_W-1:0]      in_b,
   input  logic [v4alu_pkg::WORD_W-1:0]                            in_f,
   input  logic [v4alu_pkg::TOL_W-1:0]                             tol,
   output logic                                                    out_valid,
   output v4alu_pkg::front_type                                    out_item
);
   import v4alu_pkg::*;

   localparam int MULS   = 6;
   localparam int PROD_W = 2 * WORD_W;
   localparam int ACC_W  = PROD_W + 2;

   function automatic logic [WORD_W-1:0] sat_w(input logic signed [ACC_W-1:0] v);
      if (&v[ACC_W-1:WORD_W-1] || ~|v[ACC_W-1:WORD_W-1]) begin
         return v[WORD_W-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

   // Round to nearest with ties toward plus infinity, then drop the fraction.
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] t;
      half = ACC_W'(1) << (FRAC_BITS - 1);
      t    = v + half;
      return t >>> FRAC_BITS;
   endfunction

   function automatic logic signed [ACC_W-1:0] sx(input logic [WORD_W-1:0] v);
      return ACC_W'($signed(v));
   endfunction

   // Stage one.
   logic [WORD_W-1:0]               opx [MULS];
   logic [WORD_W-1:0]               opy [MULS];
   logic signed [PROD_W-1:0]        prod_in [MULS];
   logic signed [PROD_W-1:0]        prod_ff [MULS];
   logic [LANES-1:0][WORD_W-1:0]    simp_in, simp_ff;
   logic                            eq_in, eq_ff;
   logic                            eq_all;
   logic signed [ACC_W-1:0]         diff;
   logic signed [ACC_W-1:0]         adiff;
   opcode_type                      op_ff;
   logic [LANES-1:0][WORD_W-1:0]    a_ff;
   logic [WORD_W-1:0]               f_ff;
   logic                            vld_a_ff;

   always_comb begin
      for (int k = 0; k < MULS; k++) begin
         opx[k] = '0;
         opy[k] = '0;
      end
      case (in_op)
         OP_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               opx[i] = in_a[i];
               opy[i] = in_f;
            end
         end
         OP_DOT: begin
            for (int i = 0; i < LANES; i++) begin
               opx[i] = in_a[i];
               opy[i] = in_b[i];
            end
         end
         OP_MAG, OP_NORM: begin
            for (int i = 0; i < LANES; i++) begin
               opx[i] = in_a[i];
               opy[i] = in_a[i];
            end
         end
         OP_CROSS: begin
            opx[0] = in_a[1]; opy[0] = in_b[2];
            opx[1] = in_a[2]; opy[1] = in_b[1];
            opx[2] = in_a[2]; opy[2] = in_b[0];
            opx[3] = in_a[0]; opy[3] = in_b[2];
            opx[4] = in_a[0]; opy[4] = in_b[1];
            opx[5] = in_a[1]; opy[5] = in_b[0];
         end
         default: begin
         end
      endcase
      for (int k = 0; k < MULS; k++) begin
         prod_in[k] = $signed(opx[k]) * $signed(opy[k]);
      end
   end

   always_comb begin
      eq_all = 1'b1;
      diff   = '0;
      adiff  = '0;
      for (int i = 0; i < LANES; i++) begin
         diff  = sx(in_a[i]) - sx(in_b[i]);
         adiff = (diff < 0) ? -diff : diff;
         if (!(adiff < ACC_W'(tol))) begin
            eq_all = 1'b0;
         end
         case (in_op)
            OP_ADD:  simp_in[i] = sat_w(sx(in_a[i]) + sx(in_b[i]));
            OP_SUB:  simp_in[i] = sat_w(sx(in_a[i]) - sx(in_b[i]));
            OP_NEG:  simp_in[i] = sat_w(-sx(in_a[i]));
            default: simp_in[i] = '0;
         endcase
      end
      eq_in = (in_op == OP_EQUAL) && eq_all;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < MULS; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         simp_ff <= simp_in;
         eq_ff   <= eq_in;
         op_ff   <= in_op;
         a_ff    <= in_a;
         f_ff    <= in_f;
      end
   end

   // Stage two.
   logic [LANES-1:0][WORD_W-1:0] r_in;
   logic [WORD_W-1:0]            sc_in;
   logic signed [ACC_W-1:0]      ss;
   logic [SUMSQ_W-1:0]           sumsq_in;
   logic                         vld_b_ff;
   front_type                    item_in, item_ff;

   always_comb begin
      r_in  = simp_ff;
      sc_in = '0;
      case (op_ff)
         OP_SCALE: begin
            for (int i = 0; i < LANES; i++) begin
               r_in[i] = sat_w(rnd(ACC_W'(prod_ff[i])));
            end
         end
         OP_CROSS: begin
            r_in[0] = sat_w(rnd(ACC_W'(prod_ff[0]) - ACC_W'(prod_ff[1])));
            r_in[1] = sat_w(rnd(ACC_W'(prod_ff[2]) - ACC_W'(prod_ff[3])));
            r_in[2] = sat_w(rnd(ACC_W'(prod_ff[4]) - ACC_W'(prod_ff[5])));
            r_in[3] = '0;
         end
         OP_DOT: begin
            sc_in = sat_w(rnd(ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1])
                              + ACC_W'(prod_ff[2]) + ACC_W'(prod_ff[3])));
         end
         default: begin
         end
      endcase
      // Squares are never negative; only the all-minimum vector reaches 2^64.
      ss = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
           + ACC_W'(prod_ff[3]);
      sumsq_in = (ss[ACC_W-1:SUMSQ_W] != '0) ? '1 : ss[SUMSQ_W-1:0];

      item_in.info.op = op_ff;
      item_in.info.r  = r_in;
      item_in.info.sc = sc_in;
      item_in.info.eq = eq_ff;
      item_in.info.a  = a_ff;
      item_in.info.f  = f_ff;
      item_in.sumsq   = sumsq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_b_ff;
   assign out_item  = item_ff;

endmodule

### src/v4alu_sqrt.sv
// ----------------------------------------------------------------------------
// v4alu_sqrt
// Pipelined digit-by-digit integer square root of a 64-bit value, one root
// bit per stage, followed by a stage that rounds the root to nearest.
// ----------------------------------------------------------------------------
module v4alu_sqrt #(
   parameter int TAG_W = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [v4alu_pkg::SUMSQ_W-1:0]    in_radicand,
   input  logic [TAG_W-1:0]                 in_tag,
   output logic                             out_valid,
   output logic [v4alu_pkg::ROOT_W-1:0]     out_root,
   output logic [TAG_W-1:0]                 out_tag
);
   import v4alu_pkg::*;

   localparam int STEPS = SUMSQ_W / 2;

   logic [SUMSQ_W-1:0] rem_ff [STEPS];
   logic [SUMSQ_W-1:0] res_ff [STEPS];
   logic [TAG_W-1:0]   tag_ff [STEPS];
   logic               vld_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * k);
      logic [SUMSQ_W-1:0] rem_prev, res_prev, rem_in, res_in;
      logic [TAG_W-1:0]   tag_prev;
      logic               vld_prev;
      logic [SUMSQ_W:0]   trial;

      if (k == 0) begin : g_first
         assign rem_prev = in_radicand;
         assign res_prev = '0;
         assign tag_prev = in_tag;
         assign vld_prev = in_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
         assign tag_prev = tag_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, res_prev} + {1'b0, BIT};
         if ({1'b0, rem_prev} >= trial) begin
            rem_in = rem_prev - trial[SUMSQ_W-1:0];
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   // The remainder left over is the value minus the root squared.
   logic [ROOT_W-1:0] root_in, root_ff;
   logic [TAG_W-1:0]  tag_r_ff;
   logic              vld_r_ff;

   assign root_in = ROOT_W'(res_ff[STEPS-1])
                    + ROOT_W'(rem_ff[STEPS-1] > res_ff[STEPS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_r_ff <= 1'b0;
      end else if (en) begin
         vld_r_ff <= vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff  <= root_in;
         tag_r_ff <= tag_ff[STEPS-1];
      end
   end

   assign out_valid = vld_r_ff;
   assign out_root  = root_ff;
   assign out_tag   = tag_r_ff;

endmodule

### src/v4alu_div.sv
// ----------------------------------------------------------------------------
// v4alu_div
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module v4alu_div #(
   parameter int NW    = 48,
   parameter int TAG_W = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  logic                                        in_valid,
   input  logic [v4alu_pkg::LANES-1:0][NW-1:0]         in_dividend,
   input  logic [v4alu_pkg::ROOT_W-1:0]                in_divisor,
   input  logic [TAG_W-1:0]                            in_tag,
   output logic                                        out_valid,
   output logic [v4alu_pkg::LANES-1:0][NW-1:0]         out_quot,
   output logic [TAG_W-1:0]                            out_tag
);
   import v4alu_pkg::*;

   // Each lane shifts dividend bits out of the top and quotient bits in below.
   logic [LANES-1:0][NW-1:0]     nq_ff  [NW];
   logic [LANES-1:0][ROOT_W-1:0] rem_ff [NW];
   logic [ROOT_W-1:0]            dv_ff  [NW-1];
   logic [TAG_W-1:0]             tag_ff [NW];
   logic                         vld_ff [NW];

   for (genvar j = 0; j < NW; j++) begin : g_step
      logic [LANES-1:0][NW-1:0]     nq_prev, nq_in;
      logic [LANES-1:0][ROOT_W-1:0] rem_prev, rem_in;
      logic [ROOT_W-1:0]            dv_prev;
      logic [TAG_W-1:0]             tag_prev;
      logic                         vld_prev;
      logic [ROOT_W:0]              t;
      logic                         ge;

      if (j == 0) begin : g_first
         assign nq_prev  = in_dividend;
         assign rem_prev = '0;
         assign dv_prev  = in_divisor;
         assign tag_prev = in_tag;
         assign vld_prev = in_valid;
      end else begin : g_next
         assign nq_prev  = nq_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign dv_prev  = dv_ff[j-1];
         assign tag_prev = tag_ff[j-1];
         assign vld_prev = vld_ff[j-1];
      end

      always_comb begin
         t  = '0;
         ge = 1'b0;
         for (int l = 0; l < LANES; l++) begin
            t         = {rem_prev[l], nq_prev[l][NW-1]};
            ge        = (t >= {1'b0, dv_prev});
            rem_in[l] = ge ? ROOT_W'(t - {1'b0, dv_prev}) : t[ROOT_W-1:0];
            nq_in[l]  = {nq_prev[l][NW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[j]  <= nq_in;
            rem_ff[j] <= rem_in;
            tag_ff[j] <= tag_prev;
         end
      end

      if (j < NW - 1) begin : g_dv
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[j] <= dv_prev;
            end
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quot  = nq_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

### src/vec4_alu.sv
// ----------------------------------------------------------------------------
// vec4_alu
// Four-component Q16.16 vector unit: add, subtract, negate, scale, divide,
// tolerance equality, magnitude, normalize, dot and cross, all saturating.
// ----------------------------------------------------------------------------
//
//  port group  direction  payload
//  req_*       in         opcode, a_x..a_w, b_x..b_w, factor
//  rsp_*       out        r_x..r_w, scalar_out, is_equal, fault
//  csr_*       in         equal_tolerance
//
// One item enters per cycle while the pipeline is not halted. Each item passes
// through two product stages, 33 square-root stages, one divider setup
// stage, 32 + FRAC_BITS divider stages and the output register.
// The whole pipeline moves together; it halts only while a result sits in the
// output register and rsp_tready is low, and req_tready is low for exactly
// those cycles. Reset clears the valid bits and loads a tolerance of 7.
//
module vec4_alu #(
   parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor, zero fill
   input  logic [v4alu_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // r_x, r_y, r_z, r_w, scalar_out, is_equal, fault, zero fill
   output logic [v4alu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [v4alu_pkg::TOL_W-1:0]          csr_wdata
);
   import v4alu_pkg::*;

   localparam int NW    = WORD_W + FRAC_BITS;
   localparam int A_LSB = 4;
   localparam int B_LSB = A_LSB + LANES * WORD_W;
   localparam int F_LSB = B_LSB + LANES * WORD_W;

   typedef struct packed {
      opcode_type                   op;
      logic [LANES-1:0][WORD_W-1:0] r;
      logic [WORD_W-1:0]            sc;
      logic                         eq;
      logic                         fault;
      logic [LANES-1:0]             neg;
   } post_type;

   localparam int INFO_W = $bits(info_type);
   localparam int POST_W = $bits(post_type);

   logic en;
   logic rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // Tolerance register.
   logic [TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   // Request fields.
   opcode_type                   req_op;
   logic [LANES-1:0][WORD_W-1:0] req_a, req_b;
   logic [WORD_W-1:0]            req_f;

   always_comb begin
      req_op = opcode_type'(req_tdata[3:0]);
      for (int i = 0; i < LANES; i++) begin
         req_a[i] = req_tdata[A_LSB + WORD_W * i +: WORD_W];
         req_b[i] = req_tdata[B_LSB + WORD_W * i +: WORD_W];
      end
      req_f = req_tdata[F_LSB +: WORD_W];
   end

   logic      front_vld;
   front_type front_item;

   v4alu_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_op     (req_op),
      .in_a      (req_a),
      .in_b      (req_b),
      .in_f      (req_f),
      .tol       (tol_ff),
      .out_valid (front_vld),
      .out_item  (front_item)
   );

   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   logic [INFO_W-1:0] sq_tag;
   info_type          sq_info;

   v4alu_sqrt #(
      .TAG_W (INFO_W)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (front_vld),
      .in_radicand (front_item.sumsq),
      .in_tag      (front_item.info),
      .out_valid   (sq_vld),
      .out_root    (sq_root),
      .out_tag     (sq_tag)
   );

   assign sq_info = info_type'(sq_tag);

   // Divider setup: pick the divisor and form the pre-rounded dividends.
   logic [ROOT_W-1:0]         divisor_in, divisor_ff;
   logic [LANES-1:0][NW-1:0]  dividend_in, dividend_ff;
   logic [WORD_W-1:0]         f_abs;
   logic [WORD_W-1:0]         a_abs;
   post_type                  post_in, post_ff;
   logic                      vld_d_ff;

   always_comb begin
      f_abs      = sq_info.f[WORD_W-1] ? -sq_info.f : sq_info.f;
      divisor_in = (sq_info.op == OP_NORM) ? sq_root : {1'b0, f_abs};
      a_abs      = '0;
      for (int i = 0; i < LANES; i++) begin
         a_abs          = sq_info.a[i][WORD_W-1] ? -sq_info.a[i] : sq_info.a[i];
         dividend_in[i] = (NW'(a_abs) << FRAC_BITS) + NW'(divisor_in >> 1);
         post_in.neg[i] = (sq_info.op == OP_NORM) ? sq_info.a[i][WORD_W-1]
                          : (sq_info.a[i][WORD_W-1] ^ sq_info.f[WORD_W-1]);
      end
      post_in.op    = sq_info.op;
      post_in.r     = sq_info.r;
      post_in.eq    = sq_info.eq;
      post_in.fault = ((sq_info.op == OP_DIV) && (sq_info.f == '0))
                      || ((sq_info.op == OP_NORM) && (sq_root == '0));
      if (sq_info.op == OP_MAG) begin
         post_in.sc = sq_root[ROOT_W-1:WORD_W-1] != '0 ? {1'b0, {(WORD_W-1){1'b1}}}
                      : sq_root[WORD_W-1:0];
      end else begin
         post_in.sc = sq_info.sc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
      end else if (en) begin
         vld_d_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         divisor_ff  <= divisor_in;
         dividend_ff <= dividend_in;
         post_ff     <= post_in;
      end
   end

   logic                     dv_vld;
   logic [LANES-1:0][NW-1:0] dv_quot;
   logic [POST_W-1:0]        dv_tag;
   post_type                 dv_post;

   v4alu_div #(
      .NW    (NW),
      .TAG_W (POST_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (vld_d_ff),
      .in_dividend (dividend_ff),
      .in_divisor  (divisor_ff),
      .in_tag      (post_ff),
      .out_valid   (dv_vld),
      .out_quot    (dv_quot),
      .out_tag     (dv_tag)
   );

   assign dv_post = post_type'(dv_tag);

   // Sign, saturation and result selection into the output register.
   logic [LANES-1:0][WORD_W-1:0] r_out;
   logic [WORD_W-1:0]            q_sat;

   always_comb begin
      q_sat = '0;
      for (int l = 0; l < LANES; l++) begin
         if (dv_post.neg[l]) begin
            q_sat = (dv_quot[l] > NW'({1'b1, {(WORD_W-1){1'b0}}}))
                    ? {1'b1, {(WORD_W-1){1'b0}}} : -dv_quot[l][WORD_W-1:0];
         end else begin
            q_sat = (dv_quot[l] > NW'({1'b0, {(WORD_W-1){1'b1}}}))
                    ? {1'b0, {(WORD_W-1){1'b1}}} : dv_quot[l][WORD_W-1:0];
         end
         if ((dv_post.op == OP_DIV) || (dv_post.op == OP_NORM)) begin
            r_out[l] = dv_post.fault ? '0 : q_sat;
         end else begin
            r_out[l] = dv_post.r[l];
         end
      end
      rsp_data_in = RSP_DATA_W'({dv_post.fault, dv_post.eq, dv_post.sc,
                                 r_out[3], r_out[2], r_out[1], r_out[0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A faulted item never carries a vector result.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[161] |-> rsp_tdata[127:0] == '0)
      else $error("fault result with nonzero vector");

   // Equality and fault come from different operations.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[160] && rsp_tdata[161]))
      else $error("is_equal and fault both set");

   // A held result stalls the front of the pipeline.
   a_stall_front: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");
`endif

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// vec4_alu testbench
// Drives a short table of directed vector operations and then phases of
// random items under several equality tolerances. Each accepted item's
// expected result is queued and compared field by field, in order, with
// the results leaving the unit. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import v4alu_pkg::*;

   localparam logic [3:0] OP_UNUSED   = 4'd12;
   localparam logic [3:0] OP_TOP      = 4'd15;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN       = 120;

   typedef struct packed {
      logic [31:0]       f;
      logic [3:0][31:0]  b;
      logic [3:0][31:0]  a;
      logic [3:0]        op;
   } vec_item_type;

   typedef struct packed {
      logic              fault;
      logic              eq;
      logic [31:0]       sc;
      logic [3:0][31:0]  r;
   } vec_result_type;

   typedef struct {
      vec_item_type   it;
      bit             typed;
      vec_result_type res;
   } table_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [TOL_W-1:0]      csr_wdata;

   vec_result_type result_q[$];
   vec_result_type pending_result;
   table_row_type  stim_table[$];
   longint         equal_tol;
   int             mismatches;
   int             failures;
   int             cycles;
   bit             no_idle;
   bit             rx_hold_req;

   vec4_alu u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7FFFFFFF;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Products carry 32 fraction bits; round to 16 with ties toward plus infinity.
   function automatic logic [31:0] round_prod(input logic signed [127:0] s);
      return clamp32((s + 128'sd32768) >>> 16);
   endfunction

   // Quotient a * 2^16 / d, rounded with ties away from zero.
   function automatic logic [31:0] quot_round(input longint a, input longint d);
      logic [63:0]            ua;
      logic [63:0]            ud;
      logic [63:0]            q;
      logic signed [127:0]    v;
      bit                     neg;
      neg = (a < 0) != (d < 0);
      ua = (a < 0 ? -a : a);
      ua = ua << 16;
      ud = (d < 0 ? -d : d);
      q = (ua + ud / 2) / ud;
      if (q > 64'd1 << 40) q = 64'd1 << 40;
      v = $signed({64'd0, q});
      return clamp32(neg ? -v : v);
   endfunction

   function automatic logic [63:0] length_of(input vec_item_type it);
      logic [65:0] s;
      logic [63:0] m;
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      longint      av;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         av = $signed(it.a[i]);
         m = (av < 0 ? -av : av);
         s = s + m * m;
      end
      if (s > 66'h0FFFFFFFFFFFFFFFF) s = 66'h0FFFFFFFFFFFFFFFF;
      rem = s[63:0];
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (s[63:0] - res * res > res) res = res + 1;
      return res;
   endfunction

   function automatic vec_result_type vec_predict(input vec_item_type it);
      vec_result_type      o;
      longint              av[4];
      longint              bv[4];
      longint              fv;
      longint              d;
      logic [63:0]         m;
      logic signed [127:0] acc;
      o = '0;
      for (int i = 0; i < 4; i++) begin
         av[i] = $signed(it.a[i]);
         bv[i] = $signed(it.b[i]);
      end
      fv = $signed(it.f);
      case (it.op)
         OP_ADD:   for (int i = 0; i < 4; i++) o.r[i] = clamp32(av[i] + bv[i]);
         OP_SUB:   for (int i = 0; i < 4; i++) o.r[i] = clamp32(av[i] - bv[i]);
         OP_NEG:   for (int i = 0; i < 4; i++) o.r[i] = clamp32(-av[i]);
         OP_SCALE: for (int i = 0; i < 4; i++) o.r[i] = round_prod(av[i] * fv);
         OP_DIV: begin
            if (fv == 0) o.fault = 1'b1;
            else for (int i = 0; i < 4; i++) o.r[i] = quot_round(av[i], fv);
         end
         OP_EQUAL: begin
            o.eq = 1'b1;
            for (int i = 0; i < 4; i++) begin
               d = av[i] - bv[i];
               if (d < 0) d = -d;
               if (!(d < equal_tol)) o.eq = 1'b0;
            end
         end
         OP_MAG: begin
            m = length_of(it);
            o.sc = (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
         end
         OP_NORM: begin
            m = length_of(it);
            if (m == 0) o.fault = 1'b1;
            else for (int i = 0; i < 4; i++) o.r[i] = quot_round(av[i], longint'(m));
         end
         OP_DOT: begin
            acc = 0;
            for (int i = 0; i < 4; i++) acc = acc + av[i] * bv[i];
            o.sc = round_prod(acc);
         end
         OP_CROSS: begin
            acc = 0;
            acc = acc + av[1] * bv[2];
            acc = acc - av[2] * bv[1];
            o.r[0] = round_prod(acc);
            acc = 0;
            acc = acc + av[2] * bv[0];
            acc = acc - av[0] * bv[2];
            o.r[1] = round_prod(acc);
            acc = 0;
            acc = acc + av[0] * bv[1];
            acc = acc - av[1] * bv[0];
            o.r[2] = round_prod(acc);
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic vec_item_type mk_item(input logic [3:0] op,
         input logic [31:0] ax, ay, az, aw, bx, by, bz, bw, f);
      vec_item_type it;
      it.op = op;
      it.a  = {aw, az, ay, ax};
      it.b  = {bw, bz, by, bx};
      it.f  = f;
      return it;
   endfunction

   function automatic vec_result_type mk_res(input logic [31:0] rx, ry, rz, rw, sc,
         input logic eq, input logic flt);
      vec_result_type o;
      o.r = {rw, rz, ry, rx};
      o.sc = sc;
      o.eq = eq;
      o.fault = flt;
      return o;
   endfunction

   task automatic add_row(input vec_item_type it, input bit typed,
         input vec_result_type res);
      table_row_type row;
      row.it = it;
      row.typed = typed;
      row.res = res;
      stim_table.push_back(row);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(9))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(524288)) - 262144);
         4: return 32'h00010000;
         default: return $urandom;
      endcase
   endfunction

   function automatic vec_item_type rand_item();
      vec_item_type it;
      if ($urandom_range(19) == 0) it.op = 4'($urandom_range(OP_TOP, OP_CROSS + 1));
      else it.op = 4'($urandom_range(OP_CROSS));
      for (int i = 0; i < 4; i++) begin
         it.a[i] = rand_word();
         it.b[i] = rand_word();
      end
      it.f = rand_word();
      // Near-equal vectors, so that the tolerance test is decided both ways.
      if (it.op == OP_EQUAL && $urandom_range(3) != 0)
         for (int i = 0; i < 4; i++)
            it.b[i] = it.a[i] + 32'($signed($urandom_range(40)) - 20);
      if (it.op == OP_NORM && $urandom_range(9) == 0) it.a = '0;
      return it;
   endfunction

   task automatic send(input vec_item_type it, input vec_result_type res);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {{(REQ_DATA_W - $bits(vec_item_type)){1'b0}}, it};
      pending_result = res;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Every item yields a result, so an empty queue means the unit is idle.
   task automatic write_tol(input logic [TOL_W-1:0] v);
      go_quiet();
      wait (result_q.size() == 0);
      repeat (DRAIN) @(negedge clock);
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      equal_tol = v;
   endtask

   task automatic load_table();
      localparam logic [31:0] MX = 32'h7FFFFFFF;
      localparam logic [31:0] MN = 32'h80000000;
      localparam logic [31:0] ONE = 32'h00010000;
      vec_result_type zr;
      zr = '0;
      add_row(mk_item(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zr);
      add_row(mk_item(OP_ADD, MX, MN, 1, ONE, MX, MN, -1, ONE, 0), 1,
              mk_res(MX, MN, 0, 32'h00020000, 0, 0, 0));
      add_row(mk_item(OP_SUB, MN, MX, 5, 0, 1, -1, 5, MN, 0), 1,
              mk_res(MN, MX, 0, MX, 0, 0, 0));
      add_row(mk_item(OP_NEG, MN, MX, 0, -1, 0, 0, 0, 0, 0), 1,
              mk_res(MX, 32'h80000001, 0, 1, 0, 0, 0));
      add_row(mk_item(OP_SCALE, ONE, -ONE, MX, MN, 0, 0, 0, 0, ONE), 1,
              mk_res(ONE, -ONE, MX, MN, 0, 0, 0));
      add_row(mk_item(OP_SCALE, MN, MX, 1, -1, 0, 0, 0, 0, MN), 0, zr);
      add_row(mk_item(OP_SCALE, 1, -1, 3, 32'h8000, 0, 0, 0, 0, 32'h8000), 0, zr);
      add_row(mk_item(OP_DIV, MX, MN, 1, -1, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 0, 1));
      add_row(mk_item(OP_DIV, MX, MN, 1, -1, 0, 0, 0, 0, 1), 0, zr);
      add_row(mk_item(OP_DIV, MN, MX, 3, -3, 0, 0, 0, 0, MN), 0, zr);
      add_row(mk_item(OP_DIV, 1, -1, 3, 5, 0, 0, 0, 0, 2), 0, zr);
      add_row(mk_item(OP_EQUAL, 9, MN, MX, 0, 9, MN, MX, 0, 0), 1, mk_res(0, 0, 0, 0, 0, 1, 0));
      add_row(mk_item(OP_EQUAL, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1, zr);
      add_row(mk_item(OP_EQUAL, MN, 0, 0, 0, MX, 0, 0, 0, 0), 1, zr);
      add_row(mk_item(OP_MAG, 0, 0, 0, 0, 5, 5, 5, 5, 5), 1, zr);
      add_row(mk_item(OP_MAG, MN, MN, MN, MN, 0, 0, 0, 0, 0), 1,
              mk_res(0, 0, 0, 0, MX, 0, 0));
      add_row(mk_item(OP_MAG, 32'h30000, 32'h40000, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_res(0, 0, 0, 0, 32'h50000, 0, 0));
      add_row(mk_item(OP_NORM, 0, 0, 0, 0, 1, 1, 1, 1, 1), 1, mk_res(0, 0, 0, 0, 0, 0, 1));
      add_row(mk_item(OP_NORM, MN, MN, MN, MN, 0, 0, 0, 0, 0), 0, zr);
      add_row(mk_item(OP_NORM, 32'h30000, 32'h40000, 0, 0, 0, 0, 0, 0, 0), 0, zr);
      add_row(mk_item(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, zr);
      add_row(mk_item(OP_DOT, MN, MN, MN, MN, MN, MN, MN, MN, 0), 1,
              mk_res(0, 0, 0, 0, MX, 0, 0));
      add_row(mk_item(OP_DOT, MX, MN, ONE, 3, MN, MN, -ONE, 32'h8000, 0), 0, zr);
      add_row(mk_item(OP_CROSS, ONE, 0, 0, MX, 0, ONE, 0, MN, 0), 1,
              mk_res(0, 0, ONE, 0, 0, 0, 0));
      add_row(mk_item(OP_CROSS, MN, MX, MN, 5, MX, MN, MX, 5, 0), 0, zr);
      add_row(mk_item(OP_UNUSED, MX, MX, MX, MX, MX, MX, MX, MX, 0), 1, zr);
      add_row(mk_item(OP_TOP, 1, 2, 3, 4, 5, 6, 7, 8, 9), 0, zr);
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      logic [TOL_W-1:0] tols[5];
      vec_item_type     it;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      equal_tol = 7;
      no_idle = 0;
      rx_hold_req = 0;
      pending_result = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_table();
      foreach (stim_table[k])
         send(stim_table[k].it,
              stim_table[k].typed ? stim_table[k].res : vec_predict(stim_table[k].it));

      tols[0] = '0;
      tols[1] = 31'h7FFFFFFF;
      tols[2] = 31'd1;
      tols[3] = 31'($urandom);
      tols[4] = 31'($urandom_range(65536));
      for (int p = 0; p < 5; p++) begin
         write_tol(tols[p]);
         no_idle = (p == 3);
         for (int n = 0; n < 320; n++) begin
            if (p == 1 && n == 50) rx_hold_req = 1;
            if (p == 2 && n == 160) begin
               go_quiet();
               wait (result_q.size() == 0);
            end
            if (p == 3 && n == 200) no_idle = 0;
            it = rand_item();
            send(it, vec_predict(it));
         end
      end

      go_quiet();
      wait (result_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold that backs up the pipe.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            rx_hold_req = 0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      vec_result_type act;
      vec_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) result_q.push_back(pending_result);
         if (rsp_tvalid && rsp_tready) begin
            act = rsp_tdata[$bits(vec_result_type)-1:0];
            if (result_q.size() == 0) begin
               failures++;
               mismatches++;
               if (mismatches <= 10) $display("unexpected item on rsp: %h", act);
            end else begin
               want = result_q.pop_front();
               if (act.r[0] !== want.r[0] || act.r[1] !== want.r[1] ||
                   act.r[2] !== want.r[2] || act.r[3] !== want.r[3] ||
                   act.sc !== want.sc || act.eq !== want.eq ||
                   act.fault !== want.fault) begin
                  failures++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp r=%h %h %h %h sc=%h eq=%b fault=%b,",
                               " got r=%h %h %h %h sc=%h eq=%b fault=%b"},
                              want.r[0], want.r[1], want.r[2], want.r[3], want.sc, want.eq,
                              want.fault, act.r[0], act.r[1], act.r[2], act.r[3], act.sc,
                              act.eq, act.fault);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
